### rtl/mains_voltage_stabilizer_control_assert.svh
// Assertion macros shared by the stabilizer control RTL.
`ifndef MAINS_VOLTAGE_STABILIZER_CONTROL_ASSERT_SVH
`define MAINS_VOLTAGE_STABILIZER_CONTROL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSVC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("stabilizer control: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MSVC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("stabilizer control: next-cycle check failed");

`endif

### rtl/msvc_pkg.sv
package msvc_pkg;

  localparam int SAMPLES_AVERAGED_DEF = 10;
  localparam int MAX_INDEX_DEF = 11;

  localparam int SAMPLE_W = 10;
  localparam int INDEX_W = 4;
  localparam int SUM_W = 14;
  localparam int TICK_W = 14;
  localparam int WAIT_W = 8;
  localparam int DEB_W = 6;
  localparam int BAND_W = 8;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CMP_W = 12;

  localparam logic [TICK_W-1:0] TICK_SAT = 14'd10000;
  localparam logic [WAIT_W-1:0] WAIT_SAT = 8'd250;
  localparam logic [WAIT_W-1:0] WAIT_MIN = 8'd2;
  localparam logic [TICK_W-1:0] DARK_TICKS = 14'd800;
  localparam logic [TICK_W-1:0] LIT_TICKS = 14'd200;
  localparam logic [TICK_W-1:0] PAUSE_TICKS = 14'd3000;
  localparam logic [TICK_W-1:0] PRESS_BLINK_TICKS = 14'd2980;
  localparam logic [DEB_W-1:0] DEBOUNCE_SAT = 6'd50;
  localparam logic [DEB_W-1:0] DEBOUNCE_MIN = 6'd40;
  localparam logic [INDEX_W-1:0] REPAIR_INDEX = 4'd4;

  localparam logic [SAMPLE_W-1:0] OVERVOLTAGE_RST = 10'd490;
  localparam logic [BAND_W-1:0] TRIGGER_RST = 8'd8;
  localparam logic [BAND_W-1:0] SETTLE_RST = 8'd3;
  localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 10'd420;
  localparam logic [INDEX_W-1:0] INITIAL_INDEX_RST = 4'd5;
  localparam logic [TICK_W-1:0] CHECK_PERIOD_RST = 14'd200;
  localparam logic [TICK_W-1:0] STARTUP_RST = 14'd3000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OVERVOLTAGE   = 3'd0,
    CFG_TRIGGER_BAND  = 3'd1,
    CFG_SETTLE_BAND   = 3'd2,
    CFG_SETPOINT_BASE = 3'd3,
    CFG_INITIAL_INDEX = 3'd4,
    CFG_CHECK_PERIOD  = 3'd5,
    CFG_STARTUP_TICKS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample_value;
    logic                converter_busy;
    logic                button_level;
  } in_item_t;

  typedef struct packed {
    logic                raise_drive;
    logic                lower_drive;
    logic                load_enable;
    logic                indicator_led;
    logic                start_conversion;
    logic [INDEX_W-1:0]  setting_index;
    logic                save_strobe;
    logic [SAMPLE_W-1:0] voltage_average;
  } out_item_t;

endpackage

### rtl/mains_voltage_stabilizer_control.sv
// Mains voltage stabilizer control.
// Each request on the input channel (in_valid, in_stall, in_data) is one
// millisecond tick carrying an optional converter sample, the converter busy
// flag and the raw button level. Every accepted request produces exactly one
// result on the output channel (out_valid, out_stall, out_data) with the
// raise/lower drives, load relay, indicator LED, conversion request, current
// setting index, save strobe and the latest ten-sample average.
// The tick is evaluated in one pass into the result register. One request
// is accepted every cycle unless the receiver stalls; the rate is set by that
// single result register, which is reloaded in the same cycle it is taken.
// While the receiver stalls a waiting result, in_stall is high and the result
// holds. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, which goes unchecked.
// Writing the initial index also loads the current index. Reset is
// synchronous: it restores register defaults and the power-up state (startup
// delay running, load off, no average yet) and empties the result register.
`include "mains_voltage_stabilizer_control_assert.svh"

module mains_voltage_stabilizer_control #(
  parameter int SAMPLES_AVERAGED = msvc_pkg::SAMPLES_AVERAGED_DEF,
  parameter int MAX_INDEX = msvc_pkg::MAX_INDEX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  msvc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output msvc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [msvc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [msvc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COUNT_W = $clog2(SAMPLES_AVERAGED + 1);
  localparam int RECIP_SHIFT = msvc_pkg::SUM_W + 5;
  localparam int PROD_W = msvc_pkg::SUM_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(SAMPLES_AVERAGED);
  localparam logic [msvc_pkg::INDEX_W-1:0] INDEX_MAX = msvc_pkg::INDEX_W'(MAX_INDEX);

  logic [msvc_pkg::SAMPLE_W-1:0] overvoltage_limit;
  logic [msvc_pkg::BAND_W-1:0]   trigger_band;
  logic [msvc_pkg::BAND_W-1:0]   settle_band;
  logic [msvc_pkg::SAMPLE_W-1:0] setpoint_base;
  logic [msvc_pkg::TICK_W-1:0]   check_period;
  logic [msvc_pkg::TICK_W-1:0]   startup_ticks;

  logic [msvc_pkg::TICK_W-1:0]   run_ticks, run_ticks_next;
  logic [msvc_pkg::WAIT_W-1:0]   conversion_wait, conversion_wait_next;
  logic [msvc_pkg::TICK_W-1:0]   blink_ticks, blink_ticks_next;
  logic [msvc_pkg::INDEX_W-1:0]  blinks_done, blinks_done_next;
  logic                          led_level, led_level_next;
  logic [msvc_pkg::DEB_W-1:0]    press_count, press_count_next;
  logic [msvc_pkg::DEB_W-1:0]    release_count, release_count_next;
  logic [msvc_pkg::INDEX_W-1:0]  index_reg, index_reg_next;
  logic                          starting, starting_next;
  logic                          regulating, regulating_next;
  logic [2:0]                    drive_bits, drive_bits_next;
  logic [msvc_pkg::SUM_W-1:0]    sample_sum, sample_sum_next;
  logic [COUNT_W-1:0]            sample_count, sample_count_next;
  logic [msvc_pkg::SAMPLE_W-1:0] average_reg, average_reg_next;

  msvc_pkg::out_item_t result_next;
  logic                in_accept;
  logic [PROD_W-1:0]   sum_product;
  logic [msvc_pkg::SAMPLE_W-1:0] block_average;

  assign in_stall = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Division by the block length as a multiply by a rounded-up reciprocal.
  assign sum_product = {{RECIP_SHIFT{1'b0}}, sample_sum} *
                       {{msvc_pkg::SUM_W{1'b0}}, RECIP};
  assign block_average = sum_product[RECIP_SHIFT +: msvc_pkg::SAMPLE_W];

  always_comb begin
    logic                          press;
    logic                          start_conv;
    logic signed [msvc_pkg::CMP_W-1:0] avg;
    logic signed [msvc_pkg::CMP_W-1:0] sp;
    logic signed [msvc_pkg::CMP_W-1:0] trig;
    logic signed [msvc_pkg::CMP_W-1:0] settle;
    logic signed [msvc_pkg::CMP_W-1:0] limit;

    run_ticks_next = run_ticks;
    conversion_wait_next = conversion_wait;
    blink_ticks_next = blink_ticks;
    blinks_done_next = blinks_done;
    led_level_next = led_level;
    press_count_next = press_count;
    release_count_next = release_count;
    index_reg_next = index_reg;
    starting_next = starting;
    regulating_next = regulating;
    drive_bits_next = drive_bits;
    sample_sum_next = sample_sum;
    sample_count_next = sample_count;
    average_reg_next = average_reg;
    press = 1'b0;
    start_conv = 1'b0;

    if (run_ticks_next < msvc_pkg::TICK_SAT) begin
      run_ticks_next = run_ticks_next + 1'b1;
    end
    if (conversion_wait_next < msvc_pkg::WAIT_SAT) begin
      conversion_wait_next = conversion_wait_next + 1'b1;
    end
    if (blink_ticks_next < msvc_pkg::TICK_SAT) begin
      blink_ticks_next = blink_ticks_next + 1'b1;
    end else begin
      blink_ticks_next = '0;
    end

    if (blink_ticks_next >= msvc_pkg::DARK_TICKS && blinks_done_next < index_reg_next &&
        !led_level_next) begin
      led_level_next = 1'b1;
      blink_ticks_next = '0;
      blinks_done_next = blinks_done_next + 1'b1;
    end
    if (blink_ticks_next >= msvc_pkg::LIT_TICKS && led_level_next) begin
      led_level_next = 1'b0;
      blink_ticks_next = '0;
    end
    if (blinks_done_next == index_reg_next && blink_ticks_next >= msvc_pkg::PAUSE_TICKS) begin
      blinks_done_next = '0;
      blink_ticks_next = '0;
    end

    if (in_data.button_level && press_count_next < msvc_pkg::DEBOUNCE_SAT) begin
      press_count_next = press_count_next + 1'b1;
    end
    if (!in_data.button_level && press_count_next != '0 &&
        release_count_next < msvc_pkg::DEBOUNCE_SAT) begin
      release_count_next = release_count_next + 1'b1;
    end
    if (!in_data.button_level && press_count_next > msvc_pkg::DEBOUNCE_MIN &&
        release_count_next > msvc_pkg::DEBOUNCE_MIN) begin
      press = 1'b1;
      press_count_next = '0;
      release_count_next = '0;
    end

    if (index_reg_next == '0 || index_reg_next > INDEX_MAX) begin
      index_reg_next = (msvc_pkg::REPAIR_INDEX < INDEX_MAX) ?
                       msvc_pkg::REPAIR_INDEX + 1'b1 : msvc_pkg::INDEX_W'(1);
    end
    if (press) begin
      index_reg_next = (index_reg_next < INDEX_MAX) ?
                       index_reg_next + 1'b1 : msvc_pkg::INDEX_W'(1);
      led_level_next = 1'b0;
      blinks_done_next = index_reg_next;
      blink_ticks_next = msvc_pkg::PRESS_BLINK_TICKS;
    end

    avg = $signed({2'b00, average_reg});
    sp = $signed({2'b00, setpoint_base}) + $signed({6'b0, index_reg_next, 2'b00});
    trig = $signed({4'b0, trigger_band});
    settle = $signed({4'b0, settle_band});
    limit = $signed({2'b00, overvoltage_limit});

    if (avg != '0 && avg < limit - trig && !starting_next) begin
      drive_bits_next[2] = 1'b1;
    end
    if (avg >= limit) begin
      drive_bits_next[2] = 1'b0;
    end
    if (run_ticks_next > startup_ticks) begin
      starting_next = 1'b0;
    end

    if (run_ticks_next > check_period) begin
      if (!starting_next) begin
        run_ticks_next = '0;
      end
      if (avg > sp + trig || avg < sp - trig) begin
        regulating_next = 1'b1;
      end
    end

    if (regulating_next) begin
      if (avg > sp) begin
        drive_bits_next[1:0] = 2'b10;
      end
      if (avg < sp) begin
        drive_bits_next[1:0] = 2'b01;
      end
      if (avg > sp - settle && avg < sp + settle) begin
        drive_bits_next[1:0] = 2'b00;
        regulating_next = 1'b0;
      end
    end

    if (in_data.sample_valid) begin
      if (sample_count < COUNT_FULL) begin
        sample_sum_next = sample_sum + {{(msvc_pkg::SUM_W - msvc_pkg::SAMPLE_W){1'b0}},
                                        in_data.sample_value};
        sample_count_next = sample_count + 1'b1;
      end else begin
        average_reg_next = block_average;
        sample_sum_next = '0;
        sample_count_next = '0;
      end
    end

    if (conversion_wait_next > msvc_pkg::WAIT_MIN && !in_data.converter_busy) begin
      conversion_wait_next = '0;
      start_conv = 1'b1;
    end

    result_next.raise_drive = drive_bits_next[0];
    result_next.lower_drive = drive_bits_next[1];
    result_next.load_enable = drive_bits_next[2];
    result_next.indicator_led = led_level_next;
    result_next.start_conversion = start_conv;
    result_next.setting_index = index_reg_next;
    result_next.save_strobe = (index_reg_next != index_reg) || press;
    result_next.voltage_average = average_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overvoltage_limit <= msvc_pkg::OVERVOLTAGE_RST;
      trigger_band <= msvc_pkg::TRIGGER_RST;
      settle_band <= msvc_pkg::SETTLE_RST;
      setpoint_base <= msvc_pkg::SETPOINT_RST;
      check_period <= msvc_pkg::CHECK_PERIOD_RST;
      startup_ticks <= msvc_pkg::STARTUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msvc_pkg::CFG_OVERVOLTAGE:   overvoltage_limit <= cfg_data[msvc_pkg::SAMPLE_W-1:0];
        msvc_pkg::CFG_TRIGGER_BAND:  trigger_band <= cfg_data[msvc_pkg::BAND_W-1:0];
        msvc_pkg::CFG_SETTLE_BAND:   settle_band <= cfg_data[msvc_pkg::BAND_W-1:0];
        msvc_pkg::CFG_SETPOINT_BASE: setpoint_base <= cfg_data[msvc_pkg::SAMPLE_W-1:0];
        // The initial index only loads the current index, below.
        msvc_pkg::CFG_INITIAL_INDEX: begin
        end
        msvc_pkg::CFG_CHECK_PERIOD:  check_period <= cfg_data[msvc_pkg::TICK_W-1:0];
        msvc_pkg::CFG_STARTUP_TICKS: startup_ticks <= cfg_data[msvc_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_ticks <= '0;
      conversion_wait <= '0;
      blink_ticks <= '0;
      blinks_done <= '0;
      led_level <= 1'b0;
      press_count <= '0;
      release_count <= '0;
      index_reg <= msvc_pkg::INITIAL_INDEX_RST;
      starting <= 1'b1;
      regulating <= 1'b0;
      drive_bits <= '0;
      sample_sum <= '0;
      sample_count <= '0;
      average_reg <= '0;
    end else if (cfg_we && cfg_index == msvc_pkg::CFG_INITIAL_INDEX) begin
      index_reg <= cfg_data[msvc_pkg::INDEX_W-1:0];
    end else if (in_accept) begin
      run_ticks <= run_ticks_next;
      conversion_wait <= conversion_wait_next;
      blink_ticks <= blink_ticks_next;
      blinks_done <= blinks_done_next;
      led_level <= led_level_next;
      press_count <= press_count_next;
      release_count <= release_count_next;
      index_reg <= index_reg_next;
      starting <= starting_next;
      regulating <= regulating_next;
      drive_bits <= drive_bits_next;
      sample_sum <= sample_sum_next;
      sample_count <= sample_count_next;
      average_reg <= average_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result_next;
    end
  end

  `MSVC_ASSERT_NOW(a_drive_exclusive, out_valid, !(out_data.raise_drive && out_data.lower_drive))
  `MSVC_ASSERT_NOW(a_index_in_range, out_valid,
                   out_data.setting_index != '0 && out_data.setting_index <= INDEX_MAX)
  `MSVC_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
  `MSVC_ASSERT_NEXT(a_no_request_when_busy, in_accept && in_data.converter_busy,
                    !out_data.start_conversion)

endmodule
